>>> rtl/mbrc_pkg.sv
package mbrc_pkg;

	localparam logic [8:0] HDR_LEN     = 9'd3;
	localparam logic [8:0] CRC_LEN     = 9'd2;
	localparam logic [8:0] MIN_RSP_LEN = 9'd5;
	localparam logic [8:0] CARD_POS    = 9'd4;
	localparam logic [8:0] LEN_POS     = 9'd2;
	localparam logic [8:0] POS_MAX     = 9'd511;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SHORT  = 2'd1,
		ST_BADCRC = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_buffer;
	} byte_beat_t;

	typedef struct packed {
		status_t     status;
		logic [8:0]  consumed_count;
		logic [23:0] card_number;
	} report_t;

endpackage

>>> rtl/mbrc_byte_if.sv
interface mbrc_byte_if;
	logic                valid;
	logic                ready;
	mbrc_pkg::byte_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/mbrc_report_if.sv
interface mbrc_report_if;
	logic             valid;
	logic             ready;
	mbrc_pkg::report_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/mbrc_crc16_byte.sv
module mbrc_crc16_byte (
	input  logic [15:0] crc,
	input  logic [7:0]  data_byte,
	output logic [15:0] crc_next
);
	import mbrc_pkg::*;

	always_comb begin
		logic [15:0] acc;
		acc = crc ^ {8'h00, data_byte};
		for (int k = 0; k < 8; k++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		crc_next = acc;
	end
endmodule

>>> rtl/mbrc_frame_eval.sv
module mbrc_frame_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  mbrc_pkg::byte_beat_t beat,
	output mbrc_pkg::report_t    report
);
	import mbrc_pkg::*;

	logic [8:0]  pos_q;
	logic [7:0]  len_q;
	logic [15:0] crc_q;
	logic [15:0] rcrc_q;
	logic [23:0] card_q;

	logic [7:0]  len_next;
	logic [15:0] crc_upd;
	logic [15:0] crc_next;
	logic [15:0] rcrc_next;
	logic [23:0] card_next;
	logic [8:0]  crc_end;
	logic [8:0]  frame_len;
	logic [8:0]  count;

	mbrc_crc16_byte u_crc (
		.crc       (crc_q),
		.data_byte (beat.data_byte),
		.crc_next  (crc_upd)
	);

	always_comb begin
		len_next  = (pos_q == LEN_POS) ? beat.data_byte : len_q;
		crc_end   = HDR_LEN + {1'b0, len_next};
		frame_len = crc_end + CRC_LEN;
		crc_next  = crc_q;
		rcrc_next = rcrc_q;
		if (pos_q < crc_end) begin
			crc_next = crc_upd;
		end else if (pos_q == crc_end) begin
			rcrc_next = {rcrc_q[15:8], beat.data_byte};
		end else if (pos_q == crc_end + 9'd1) begin
			rcrc_next = {beat.data_byte, rcrc_q[7:0]};
		end
		card_next = card_q;
		case (pos_q)
			CARD_POS:         card_next = {card_q[23:8], beat.data_byte};
			CARD_POS + 9'd1:  card_next = {card_q[23:16], beat.data_byte, card_q[7:0]};
			CARD_POS + 9'd2:  card_next = {beat.data_byte, card_q[15:0]};
			default:          card_next = card_q;
		endcase
		count = (pos_q == POS_MAX) ? POS_MAX : pos_q + 9'd1;

		if (count < MIN_RSP_LEN || count < frame_len) begin
			report.status         = ST_SHORT;
			report.consumed_count = 9'd0;
			report.card_number    = 24'd0;
		end else if (rcrc_next != crc_next) begin
			report.status         = ST_BADCRC;
			report.consumed_count = HDR_LEN;
			report.card_number    = 24'd0;
		end else begin
			report.status         = ST_OK;
			report.consumed_count = frame_len;
			report.card_number    = card_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 9'd0;
			len_q  <= 8'd0;
			crc_q  <= CRC_INIT;
			rcrc_q <= 16'd0;
			card_q <= 24'd0;
		end else if (step) begin
			if (beat.last_in_buffer) begin
				pos_q  <= 9'd0;
				len_q  <= 8'd0;
				crc_q  <= CRC_INIT;
				rcrc_q <= 16'd0;
				card_q <= 24'd0;
			end else begin
				pos_q  <= count;
				len_q  <= len_next;
				crc_q  <= crc_next;
				rcrc_q <= rcrc_next;
				card_q <= card_next;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && beat.last_in_buffer |=> pos_q == 9'd0 && crc_q == CRC_INIT)
		else $error("Frame state was not cleared after the last byte.");
endmodule

>>> rtl/modbus_response_frame_checker_unit.sv
// Checks Modbus RTU response buffers against their CRC-16/MODBUS trailer.
// The bytes channel carries one buffer byte per beat, with last_in_buffer
// set on the final byte. The report channel carries one beat per buffer:
// the status, the number of bytes to drop and the card number.
// Each byte is first taken into an input register; from there it updates the
// frame state and, on the last byte, the report is loaded into the output
// register. One byte is accepted in every cycle unless the last byte of a
// buffer waits in the input register for the output register to free; the
// rate is set by the single-byte CRC update between the two registers.
// When the receiver stalls, the report waits in the output register and
// bytes of the next buffer keep flowing until its own last byte reaches the
// input register, which then holds until the report is taken.
// Reset empties both registers and returns the frame state to its start.
module modbus_response_frame_checker_unit (
	input logic           clk,
	input logic           arst_n,
	mbrc_byte_if.sink     bytes,
	mbrc_report_if.source report
);
	import mbrc_pkg::*;

	logic       valid_s1;
	byte_beat_t beat_s1;
	logic       out_valid_q;
	report_t    out_q;
	report_t    frame_report;
	logic       out_free;
	logic       advance;

	assign out_free    = !out_valid_q || report.ready;
	assign advance     = valid_s1 && (!beat_s1.last_in_buffer || out_free);
	assign bytes.ready = !valid_s1 || advance;

	assign report.valid   = out_valid_q;
	assign report.payload = out_q;

	mbrc_frame_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.report (frame_report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			beat_s1 <= bytes.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && beat_s1.last_in_buffer) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.last_in_buffer) begin
			out_q <= frame_report;
		end
	end

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_OK |-> out_q.consumed_count >= MIN_RSP_LEN)
		else $error("Accepted frame reports fewer bytes than the minimum.");

	a_card_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.card_number == 24'd0)
		else $error("Card number is not zero on a failed frame.");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_SHORT |-> out_q.consumed_count == 9'd0)
		else $error("Short buffer reports consumed bytes.");

	a_badcrc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_BADCRC |-> out_q.consumed_count == HDR_LEN)
		else $error("Checksum mismatch does not drop the header.");
endmodule
